// ===== hw/rtl/sba_pkg.sv =====
// Shared types and constants for the spectrum band log averager.
package sba_pkg;

    // One FFT bin as it arrives on the input channel.
    typedef struct packed {
        logic signed [31:0] re_part;
        logic signed [31:0] im_part;
    } in_item_t;

    // One band level as it leaves on the result channel.
    typedef struct packed {
        logic [5:0]  band_index;
        logic [15:0] level;
        logic        last_of_run;
        logic        frame_done;
    } out_item_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_RE,
        S_SQ_IM,
        S_SQRT,
        S_ACC,
        S_DIV_INIT,
        S_DIV,
        S_NORM_INIT,
        S_NORM,
        S_LOG_INIT,
        S_LOG,
        S_SCALE,
        S_ROUND,
        S_EMIT,
        S_CHECK,
        S_DONE
    } ctrl_state_t;

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SQ_RE,
        OP_SQ_IM,
        OP_SQRT,
        OP_ACC,
        OP_DIV_INIT,
        OP_DIV,
        OP_NORM_INIT,
        OP_NORM,
        OP_LOG_INIT,
        OP_LOG,
        OP_SCALE,
        OP_ROUND,
        OP_EMIT_BAND,
        OP_EMIT_ZERO
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   finish;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic close;
        logic norm_done;
        logic zero_pend;
    } dp_status_t;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_BINS_PER_GROUP = 2'd0;
    localparam logic [1:0] REG_FRAME_BINS     = 2'd1;
    localparam logic [1:0] REG_GROUP_COUNT    = 2'd2;

    // Last iteration indexes of the multi-cycle units, and the cap on words per run.
    localparam logic [5:0] SQRT_LAST  = 6'd31;
    localparam logic [5:0] DIV_LAST   = 6'd44;
    localparam logic [5:0] LOG_LAST   = 6'd23;
    localparam logic [5:0] RESULT_CAP = 6'd33;

    // round(100*log10(2)*2^24)
    localparam logic [28:0] LOG_K = 29'd505044526;

endpackage

// ===== hw/rtl/sba_ctrl.sv =====
// Sequencing controller for the spectrum band log averager.
module sba_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sba_pkg::dp_status_t status,
    output sba_pkg::dp_cmd_t   cmd
);
    import sba_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;

    // State and iteration counter registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and datapath command.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NOP;
        cmd.finish = 1'b0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_SQ_RE;
                end
            end
            S_SQ_RE: begin
                cmd.op     = OP_SQ_RE;
                state_next = S_SQ_IM;
            end
            S_SQ_IM: begin
                cmd.op     = OP_SQ_IM;
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT: begin
                cmd.op   = OP_SQRT;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == SQRT_LAST) begin
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                cmd.op     = OP_ACC;
                state_next = status.close ? S_DIV_INIT : S_CHECK;
            end
            S_DIV_INIT: begin
                cmd.op     = OP_DIV_INIT;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.op   = OP_DIV;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = S_NORM_INIT;
                end
            end
            S_NORM_INIT: begin
                cmd.op     = OP_NORM_INIT;
                state_next = S_NORM;
            end
            S_NORM: begin
                if (status.norm_done) begin
                    state_next = S_LOG_INIT;
                end else begin
                    cmd.op = OP_NORM;
                end
            end
            S_LOG_INIT: begin
                cmd.op     = OP_LOG_INIT;
                cnt_next   = '0;
                state_next = S_LOG;
            end
            S_LOG: begin
                cmd.op   = OP_LOG;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == LOG_LAST) begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE: begin
                cmd.op     = OP_SCALE;
                state_next = S_ROUND;
            end
            S_ROUND: begin
                cmd.op     = OP_ROUND;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (status.out_free) begin
                    cmd.op     = OP_EMIT_BAND;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                // Trailing zero bands of a finished frame go out one per word.
                if (!status.zero_pend) begin
                    state_next = S_DONE;
                end else if (status.out_free) begin
                    cmd.op = OP_EMIT_ZERO;
                end
            end
            S_DONE: begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/sba_dpath.sv =====
// Datapath: magnitude, band sum, divider, log unit and result register.
module sba_dpath (
    input  logic               aclk,
    input  logic               aresetn,
    input  sba_pkg::dp_cmd_t   cmd,
    output sba_pkg::dp_status_t status,
    input  sba_pkg::in_item_t  s_data,
    input  logic [12:0]        bpg,
    input  logic [16:0]        fb,
    input  logic [6:0]         gc,
    output logic               m_valid,
    input  logic               m_ready,
    output sba_pkg::out_item_t m_data
);
    import sba_pkg::*;

    logic [31:0] a_reg, b_reg;
    logic [63:0] sq_reg;
    logic [32:0] srem_reg;
    logic [31:0] root_reg;
    logic [44:0] sum_reg;
    logic [12:0] fill_reg;
    logic [6:0]  cur_reg;
    logic [16:0] fp_reg;
    logic        last_reg;
    logic [44:0] quo_reg;
    logic [12:0] drem_reg;
    logic [12:0] dvs_reg;
    logic [45:0] x_reg;
    logic [4:0]  sh_reg;
    logic [30:0] m_reg;
    logic [28:0] l2_reg;
    logic [57:0] scl_reg;
    logic [15:0] level_reg;
    logic [5:0]  n_reg;
    out_item_t   out_reg;
    logic        out_valid_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [34:0] s_trial, s_sub;
    logic [13:0] d_trial;
    logic [12:0] fill_inc;
    logic [17:0] fp_inc;
    logic        in_band, last_c;
    logic [7:0]  cur_inc;
    logic        more_band, final_band, final_zero;
    logic [58:0] rnd;
    logic [44:0] avg;

    // One shared multiplier serves the squares, the log rounds and the scaling.
    always_comb begin
        unique case (cmd.op)
            OP_SQ_RE: begin mul_a = a_reg; mul_b = a_reg; end
            OP_SQ_IM: begin mul_a = b_reg; mul_b = b_reg; end
            OP_LOG:   begin mul_a = {1'b0, m_reg}; mul_b = {1'b0, m_reg}; end
            OP_SCALE: begin mul_a = {3'b0, l2_reg}; mul_b = {3'b0, LOG_K}; end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign prod = mul_a * mul_b;

    // Square root step, divider step and band bookkeeping.
    assign s_trial  = {srem_reg, sq_reg[63:62]};
    assign s_sub    = {1'b0, root_reg, 2'b01};
    assign d_trial  = {drem_reg, quo_reg[44]};
    assign fill_inc = fill_reg + 13'd1;
    assign fp_inc   = {1'b0, fp_reg} + 18'd1;
    assign in_band  = cur_reg < gc;
    assign last_c   = fp_inc >= {1'b0, fb};
    assign cur_inc  = {1'b0, cur_reg} + 8'd1;
    assign more_band  = cur_inc < {1'b0, gc};
    assign final_band = !(last_reg && more_band);
    assign final_zero = !(more_band && ((n_reg + 6'd1) < RESULT_CAP));
    assign rnd = {1'b0, scl_reg} + (59'd1 << 41);
    assign avg = (dvs_reg == '0) ? '0 : quo_reg;

    assign status = '{out_free:  !out_valid_reg || m_ready,
                      close:     in_band && ((fill_inc >= bpg) || last_c),
                      norm_done: x_reg[45],
                      zero_pend: last_reg && in_band && (n_reg < RESULT_CAP)};

    // Arithmetic registers that need no reset.
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD: begin
                a_reg <= s_data.re_part[31] ? (~s_data.re_part + 32'd1) : s_data.re_part;
                b_reg <= s_data.im_part[31] ? (~s_data.im_part + 32'd1) : s_data.im_part;
            end
            OP_SQ_RE: sq_reg <= prod;
            OP_SQ_IM: begin
                sq_reg   <= sq_reg + prod;
                srem_reg <= '0;
                root_reg <= '0;
            end
            OP_SQRT: begin
                sq_reg <= {sq_reg[61:0], 2'b00};
                if (s_trial >= s_sub) begin
                    srem_reg <= 33'(s_trial - s_sub);
                    root_reg <= {root_reg[30:0], 1'b1};
                end else begin
                    srem_reg <= s_trial[32:0];
                    root_reg <= {root_reg[30:0], 1'b0};
                end
            end
            OP_DIV_INIT: begin
                quo_reg  <= sum_reg;
                drem_reg <= '0;
                dvs_reg  <= fill_reg;
            end
            OP_DIV: begin
                if (d_trial >= {1'b0, dvs_reg}) begin
                    drem_reg <= 13'(d_trial - {1'b0, dvs_reg});
                    quo_reg  <= {quo_reg[43:0], 1'b1};
                end else begin
                    drem_reg <= d_trial[12:0];
                    quo_reg  <= {quo_reg[43:0], 1'b0};
                end
            end
            OP_NORM_INIT: begin
                x_reg  <= {1'b0, avg} + 46'd65536;
                sh_reg <= '0;
            end
            OP_NORM: begin
                x_reg  <= {x_reg[44:0], 1'b0};
                sh_reg <= sh_reg + 5'd1;
            end
            OP_LOG_INIT: begin
                m_reg  <= x_reg[45:15];
                l2_reg <= 29'd29 - {24'd0, sh_reg};
            end
            OP_LOG: begin
                // One fraction bit of log2 per squaring.
                if (prod[61]) begin
                    m_reg  <= prod[61:31];
                    l2_reg <= {l2_reg[27:0], 1'b1};
                end else begin
                    m_reg  <= prod[60:30];
                    l2_reg <= {l2_reg[27:0], 1'b0};
                end
            end
            OP_SCALE: scl_reg <= prod[57:0];
            OP_ROUND: level_reg <= (rnd[58:42] > 17'd65535) ? 16'hFFFF : rnd[57:42];
            default: begin
            end
        endcase
    end

    // Band state, frame position and the result word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            fill_reg      <= '0;
            cur_reg       <= '0;
            fp_reg        <= '0;
            last_reg      <= 1'b0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            // The result word is held until the receiver takes it.
            if (cmd.op == OP_EMIT_BAND || cmd.op == OP_EMIT_ZERO) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.op == OP_ACC) begin
                if (in_band) begin
                    sum_reg  <= sum_reg + {13'd0, root_reg};
                    fill_reg <= fill_inc;
                end
                last_reg <= last_c;
                fp_reg   <= last_c ? '0 : fp_inc[16:0];
                n_reg    <= '0;
            end
            if (cmd.op == OP_EMIT_BAND) begin
                out_reg.band_index  <= cur_reg[5:0];
                out_reg.level       <= level_reg;
                out_reg.last_of_run <= final_band;
                out_reg.frame_done  <= !more_band || (final_band && last_reg);
                sum_reg             <= '0;
                fill_reg            <= '0;
                cur_reg             <= cur_inc[6:0];
                n_reg               <= n_reg + 6'd1;
            end
            if (cmd.op == OP_EMIT_ZERO) begin
                out_reg.band_index  <= cur_reg[5:0];
                out_reg.level       <= '0;
                out_reg.last_of_run <= final_zero;
                out_reg.frame_done  <= final_zero;
                cur_reg             <= cur_inc[6:0];
                n_reg               <= n_reg + 6'd1;
            end
            // A finished frame starts the next one from empty bands.
            if (cmd.finish && last_reg) begin
                sum_reg  <= '0;
                fill_reg <= '0;
                cur_reg  <= '0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== hw/rtl/spectrum_band_log_averager.sv =====
// Top level: configuration registers, controller and datapath of the band log averager.
// An item that closes no band passes the squares, the square root and the accumulate step before ready returns.
// An item that closes a band then passes the divider, normalize, log setup, the log rounds,
// scale, round and emit to its first word; further words follow as the receiver takes them.
// Throughput: one item at a time, set by the bit-serial square root and divider.
// Reset (aresetn, synchronous, low): registers take 512/16384/64 and band state clears.
module spectrum_band_log_averager #(
    parameter int MAX_BANDS     = 64,
    parameter int MAX_BAND_BINS = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sba_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sba_pkg::out_item_t m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import sba_pkg::*;

    localparam logic [16:0] MAXB = 17'(MAX_BAND_BINS);
    localparam logic [6:0]  MAXG = 7'(MAX_BANDS);

    logic [12:0] bpg_reg;
    logic [16:0] fb_reg;
    logic [6:0]  gc_reg;
    logic [12:0] bpg_eff;
    logic [16:0] fb_eff;
    logic [6:0]  gc_eff;
    logic        wr_en;
    dp_cmd_t     cmd;
    dp_status_t  status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpg_reg <= 13'd512;
            fb_reg  <= 17'd16384;
            gc_reg  <= 7'd64;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_BINS_PER_GROUP: bpg_reg <= pwdata[12:0];
                REG_FRAME_BINS:     fb_reg  <= pwdata[16:0];
                REG_GROUP_COUNT:    gc_reg  <= pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (paddr[3:2])
            REG_BINS_PER_GROUP: prdata = {19'd0, bpg_reg};
            REG_FRAME_BINS:     prdata = {15'd0, fb_reg};
            REG_GROUP_COUNT:    prdata = {25'd0, gc_reg};
            default:            prdata = '0;
        endcase
    end

    // Clamp the registers to their working ranges.
    always_comb begin
        if (bpg_reg == '0) begin
            bpg_eff = 13'd1;
        end else if ({4'd0, bpg_reg} > MAXB) begin
            bpg_eff = MAXB[12:0];
        end else begin
            bpg_eff = bpg_reg;
        end
        if (fb_reg == '0) begin
            fb_eff = 17'd1;
        end else if (fb_reg > 17'd65536) begin
            fb_eff = 17'd65536;
        end else begin
            fb_eff = fb_reg;
        end
        gc_eff = (gc_reg > MAXG) ? MAXG : gc_reg;
    end

    sba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sba_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_data  (s_data),
        .bpg     (bpg_eff),
        .fb      (fb_eff),
        .gc      (gc_eff),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef NO_ASSERTIONS
    // An accepted word starts multi-cycle work, so the input closes at once.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input ready right after an accepted word");

    // While a run of results is incomplete no new input is taken.
    a_run_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.last_of_run) |-> !s_ready)
        else $error("input ready in the middle of a result run");

    // The last band of a frame always ends its run.
    a_frame_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.frame_done) |-> m_data.last_of_run)
        else $error("frame done without end of run");
`endif

endmodule

// ===== sim/tb_spectrum_band_log_averager.sv =====
// Self-checking testbench for the spectrum band log averager, with its own band level predictor.
module tb_spectrum_band_log_averager;
    import sba_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    spectrum_band_log_averager dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Bins waiting to be sent and band levels waiting to arrive.
    in_item_t  bin_q[$];
    out_item_t band_q[$];
    int        bins_pushed;
    int        bins_taken;
    int        errors;
    int        send_idle_pct;
    int        recv_idle_pct;
    bit        taken;

    // Shadow copy of the registers and of the band state.
    logic [12:0] sh_bins_per_group;
    logic [16:0] sh_frame_bins;
    logic [6:0]  sh_group_count;
    logic [44:0] sh_band_sum;
    logic [12:0] sh_band_fill;
    int unsigned sh_band;
    logic [16:0] sh_frame_pos;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

    // Integer square root of a 64-bit value, bit by bit.
    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 100*log10(1+avg/65536) in Q10.6, through a log2 with 24 squaring rounds.
    function automatic logic [15:0] log_level(logic [63:0] avg);
        logic [63:0] x;
        logic [63:0] m;
        logic [63:0] l2;
        logic [63:0] lv;
        int unsigned e;
        x = avg + 64'd65536;
        e = 0;
        while (e < 63 && (x >> (e + 1)) != 0) e++;
        if (e > 30) m = x >> (e - 30);
        else m = x << (30 - e);
        l2 = 64'(e - 16);
        for (int i = 0; i < 24; i++) begin
            m = (m * m) >> 30;
            l2 = l2 << 1;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                l2 = l2 | 64'd1;
            end
        end
        lv = (l2 * 64'(LOG_K) + (64'd1 << 41)) >> 42;
        if (lv > 64'd65535) lv = 64'd65535;
        return lv[15:0];
    endfunction

    function automatic logic [63:0] abs_part(logic signed [31:0] v);
        if (v[31]) return 64'h1_0000_0000 - {32'h0, v};
        return {32'h0, v};
    endfunction

    // Work out the band levels that one accepted bin causes.
    function automatic void predict_bands(in_item_t bin);
        int unsigned bpg;
        int unsigned fb;
        int unsigned gc;
        int unsigned cnt;
        bit          last;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] mag;
        logic [63:0] avg;
        out_item_t   r;
        out_item_t   runs[$];
        bpg = sh_bins_per_group;
        fb = sh_frame_bins;
        gc = sh_group_count;
        if (bpg < 1) bpg = 1;
        if (bpg > 4096) bpg = 4096;
        if (fb < 1) fb = 1;
        if (fb > 65536) fb = 65536;
        if (gc > 64) gc = 64;
        last = (sh_frame_pos + 1 >= fb);

        if (sh_band < gc) begin
            a = abs_part(bin.re_part);
            b = abs_part(bin.im_part);
            mag = isqrt(a * a + b * b);
            sh_band_sum = sh_band_sum + mag[44:0];
            sh_band_fill = sh_band_fill + 13'd1;
            if (sh_band_fill >= bpg || last) begin
                avg = (sh_band_fill != 0) ? {19'h0, sh_band_sum} / sh_band_fill : 0;
                r.band_index = sh_band[5:0];
                r.level = log_level(avg);
                r.last_of_run = 1'b0;
                r.frame_done = (sh_band + 1 == gc);
                runs.push_back(r);
                sh_band_sum = 0;
                sh_band_fill = 0;
                sh_band++;
            end
        end

        if (last) begin
            // Zero levels for the bands the frame never reached, up to the cap.
            for (int unsigned bnd = sh_band; bnd < gc && runs.size() < 33; bnd++) begin
                r.band_index = bnd[5:0];
                r.level = 16'd0;
                r.last_of_run = 1'b0;
                r.frame_done = (bnd + 1 == gc);
                runs.push_back(r);
            end
            if (runs.size() > 0) runs[runs.size() - 1].frame_done = 1'b1;
            sh_band_sum = 0;
            sh_band_fill = 0;
            sh_band = 0;
            sh_frame_pos = 0;
        end else begin
            sh_frame_pos = sh_frame_pos + 17'd1;
        end

        cnt = runs.size();
        if (cnt > 0) runs[cnt - 1].last_of_run = 1'b1;
        foreach (runs[i]) band_q.push_back(runs[i]);
    endfunction

    // Input side: note each accepted word and predict its levels.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            predict_bands(s_data);
            bins_taken++;
            taken = 1'b1;
        end
    end

    // Input driver: keeps valid and payload steady until the word is taken.
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || taken)) begin
            if (bin_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data <= bin_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
        taken = 1'b0;
        m_ready <= aresetn && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Result monitor: compare each word with the oldest expected level.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (band_q.size() == 0) begin
                $error("unexpected word: band_index %0d level %0d",
                       m_data.band_index, m_data.level);
                errors++;
            end else begin
                out_item_t want;
                want = band_q.pop_front();
                if (m_data.band_index !== want.band_index) begin
                    $error("band_index: expected %0d, got %0d",
                           want.band_index, m_data.band_index);
                    errors++;
                end
                if (m_data.level !== want.level) begin
                    $error("level: expected %0d, got %0d", want.level, m_data.level);
                    errors++;
                end
                if (m_data.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %0d, got %0d",
                           want.last_of_run, m_data.last_of_run);
                    errors++;
                end
                if (m_data.frame_done !== want.frame_done) begin
                    $error("frame_done: expected %0d, got %0d",
                           want.frame_done, m_data.frame_done);
                    errors++;
                end
            end
        end
    end

    // Register write over the configuration port: setup, then access.
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_BINS_PER_GROUP: sh_bins_per_group = val[12:0];
            REG_FRAME_BINS:     sh_frame_bins = val[16:0];
            REG_GROUP_COUNT:    sh_group_count = val[6:0];
            default: ;
        endcase
    endtask

    task automatic set_bands(input int bpg, input int fb, input int gc);
        reg_write(REG_BINS_PER_GROUP, bpg);
        reg_write(REG_FRAME_BINS, fb);
        reg_write(REG_GROUP_COUNT, gc);
    endtask

    task automatic send_bin(input logic [31:0] re, input logic [31:0] im);
        in_item_t it;
        it.re_part = re;
        it.im_part = im;
        bin_q.push_back(it);
        bins_pushed++;
    endtask

    // Random bin content over several magnitude scales.
    function automatic logic [31:0] rand_part();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 20)
                                           : -$urandom_range(0, 1 << 20);
            2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // Wait for every bin to go in and every level to come out, then let the block settle.
    task automatic drain();
        while (bins_taken < bins_pushed || band_q.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    initial begin
        int bpg;
        int fb;
        int gc;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        bins_pushed = 0;
        bins_taken = 0;
        taken = 1'b0;
        send_idle_pct = 16;
        recv_idle_pct = 52;
        sh_bins_per_group = 13'd512;
        sh_frame_bins = 17'd16384;
        sh_group_count = 7'd64;
        sh_band_sum = '0;
        sh_band_fill = '0;
        sh_band = 0;
        sh_frame_pos = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Field extremes over one full frame of four bands.
        set_bands(2, 8, 4);
        send_bin(32'h8000_0000, 32'h8000_0000);
        send_bin(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_bin(32'h0, 32'h0);
        send_bin(32'h0, 32'h0);
        send_bin(32'h8000_0000, 32'h0);
        send_bin(32'h1, 32'hFFFF_FFFF);
        send_bin(32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_bin(32'h0001_0000, 32'hFFFF_0000);
        drain();
        // Bins past the last band are dropped.
        set_bands(2, 6, 2);
        repeat (6) send_bin($urandom, $urandom);
        drain();
        // Frame ends inside a band, then a trailing zero band.
        set_bands(3, 4, 3);
        repeat (4) send_bin(rand_part(), rand_part());
        drain();
        // One bin frame over 64 bands: the run stops at the result cap.
        set_bands(1, 1, 64);
        send_bin(32'h0012_3456, 32'hFFF0_0000);
        drain();
        // Zero registers are clamped to one.
        set_bands(0, 0, 5);
        send_bin(32'h7FFF_FFFF, 32'h8000_0000);
        drain();
        // Oversized registers are clamped to their maxima.
        set_bands(8191, 5, 127);
        repeat (5) send_bin(rand_part(), rand_part());
        drain();
        // No bands at all: every bin is dropped.
        set_bands(4, 10, 0);
        repeat (3) send_bin($urandom, $urandom);
        drain();
        // Registers changed in the middle of a frame; the frame end is overrun.
        set_bands(2, 10, 3);
        repeat (3) send_bin(rand_part(), rand_part());
        drain();
        set_bands(3, 2, 3);
        send_bin(rand_part(), rand_part());
        drain();

        // Random frames under changing band layouts and flow control.
        for (int ph = 0; ph < 9; ph++) begin
            if (ph == 3) begin
                send_idle_pct = 52;
                recv_idle_pct = 16;
            end else if (ph == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            bpg = ($urandom_range(0, 7) == 0) ? 4096 : $urandom_range(1, 6);
            fb = ($urandom_range(0, 7) == 0) ? 65536 : $urandom_range(1, 48);
            case ($urandom_range(0, 9))
                0: gc = 64;
                1: gc = 0;
                default: gc = $urandom_range(1, 16);
            endcase
            set_bands(bpg, fb, gc);
            repeat (33) send_bin(rand_part(), rand_part());
            drain();
        end

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
